>>> rtl/core/tga_rle_pkg.sv
`default_nettype none

package tga_rle_pkg;

  typedef enum logic [1:0] {
    FUNC_BYTE  = 2'd0,
    FUNC_STEP  = 2'd1,
    FUNC_PAL   = 2'd2,
    FUNC_START = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    FMT_PAL8  = 2'd0,
    FMT_RGB16 = 2'd1,
    FMT_RGB24 = 2'd2,
    FMT_RGB32 = 2'd3
  } pix_fmt_t;

  typedef enum logic [1:0] {
    REG_PIXEL_FORMAT  = 2'd0,
    REG_COMPRESSED    = 2'd1,
    REG_DITHER_ENABLE = 2'd2
  } cfg_reg_t;

  localparam int InDataW  = 48;
  localparam int OutDataW = 24;

  localparam logic [7:0] RepeatBase = 8'd127;

  // 4x4 ordered dither threshold, indexed by x then y
  function automatic logic [3:0] dither_val(input logic [1:0] x, input logic [1:0] y);
    logic [3:0] d;
    unique case ({x, y})
      4'h0: d = 4'd4;   4'h1: d = 4'd12;  4'h2: d = 4'd6;   4'h3: d = 4'd14;
      4'h4: d = 4'd10;  4'h5: d = 4'd0;   4'h6: d = 4'd8;   4'h7: d = 4'd2;
      4'h8: d = 4'd7;   4'h9: d = 4'd15;  4'hA: d = 4'd5;   4'hB: d = 4'd13;
      4'hC: d = 4'd9;   4'hD: d = 4'd3;   4'hE: d = 4'd11;  4'hF: d = 4'd1;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] c, input logic [3:0] d);
    logic [8:0] t;
    t = {1'b0, c} + {5'd0, d};
    return t[8] ? 8'hFF : t[7:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/tga_rle_pixel_decoder.sv
`default_nettype none
// A word accepted on in_ goes through the input stage, then the result reg, to out_.
// Throughput: one word per cycle unless out_ stalls; an empty input stage still takes a word.
// The only memory is the palette: one registered read per accepted word, plus a write for palette words.
// Reset (rst_n low, synchronous): clears run state, gathered bytes, pipeline valids and
// config registers (pixel_format=24-bit, compressed=0, dither_enable=0).
// Palette contents are undefined until written; no clearing pass is made.

module tga_rle_pixel_decoder #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // tdata: data_byte[7:0], x_low[9:8], y_low[11:10], pal_index[19:12], pal_red[27:20],
  //        pal_green[35:28], pal_blue[43:36], zero fill [47:44]
  input  wire logic [tga_rle_pkg::InDataW-1:0]  in_tdata,
  // tuser: func[1:0]
  input  wire logic [1:0]                    in_tuser,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // tdata: colour[15:0], next_needs_byte[16], misuse[17], zero fill [23:18]
  output logic [tga_rle_pkg::OutDataW-1:0]   out_tdata,
  // tuser: pixel_valid[0]
  output logic                               out_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_addr,
  input  wire logic [1:0]                    cfg_wdata
);
  import tga_rle_pkg::*;

  localparam int IdxW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  // ---------------- configuration registers ----------------
  pix_fmt_t pixel_format_r;
  logic     compressed_r;
  logic     dither_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r  <= FMT_RGB24;
      compressed_r    <= 1'b0;
      dither_enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_PIXEL_FORMAT:  pixel_format_r  <= pix_fmt_t'(cfg_wdata);
        REG_COMPRESSED:    compressed_r    <= cfg_wdata[0];
        REG_DITHER_ENABLE: dither_enable_r <= cfg_wdata[0];
        default: ;  // index beyond the list: drop the write
      endcase
    end
  end

  // ---------------- input word fields ----------------
  logic [7:0] in_byte, in_pal_index, in_red, in_green, in_blue;
  logic [1:0] in_x, in_y;
  func_t      in_func;

  assign in_byte      = in_tdata[7:0];
  assign in_x         = in_tdata[9:8];
  assign in_y         = in_tdata[11:10];
  assign in_pal_index = in_tdata[19:12];
  assign in_red       = in_tdata[27:20];
  assign in_green     = in_tdata[35:28];
  assign in_blue      = in_tdata[43:36];
  assign in_func      = func_t'(in_tuser);

  // ---------------- pipeline handshake ----------------
  logic s1_valid_r, out_valid_r;
  logic s1_adv, in_acc;

  // Stage 1 moves on when the result register is free or being drained this cycle.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------- palette memory ----------------
  // Write and read both happen at acceptance, so a read always sees every earlier write.
  logic [23:0] pal_mem [PALETTE_ENTRIES];
  logic [23:0] pal_rd_r;
  logic        pal_ok_r;
  logic        in_idx_ok, in_byte_ok;

  assign in_idx_ok  = ({1'b0, in_pal_index} < 9'(PALETTE_ENTRIES));
  assign in_byte_ok = ({1'b0, in_byte} < 9'(PALETTE_ENTRIES));

  always_ff @(posedge clk) begin
    if (in_acc && in_func == FUNC_PAL && in_idx_ok) begin
      pal_mem[in_pal_index[IdxW-1:0]] <= {in_red, in_green, in_blue};
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pal_rd_r <= pal_mem[in_byte[IdxW-1:0]];
      pal_ok_r <= in_byte_ok;
    end
  end

  // ---------------- stage 1 input register ----------------
  func_t      s1_func_r;
  logic [7:0] s1_byte_r;
  logic [1:0] s1_x_r, s1_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_func;
      s1_byte_r <= in_byte;
      s1_x_r    <= in_x;
      s1_y_r    <= in_y;
    end
  end

  // ---------------- decoder state ----------------
  logic [7:0]  run_count_r,      run_count_nxt;
  logic        run_is_repeat_r,  run_is_repeat_nxt;
  logic        held_valid_r,     held_valid_nxt;
  logic [23:0] held_rgb_r,       held_rgb_nxt;
  logic [23:0] gathered_r,       gathered_nxt;
  logic [1:0]  byte_pos_r,       byte_pos_nxt;

  logic        holding, holding_nxt;
  logic [23:0] asm_rgb;         // pixel assembled from gathered bytes and this byte
  logic [23:0] pix_rgb;         // colour source before dither
  logic        valid_c, misuse_c;
  logic [7:0]  b0, b1, b2;

  assign holding = compressed_r && run_is_repeat_r && held_valid_r && (run_count_r != 8'd0);
  assign b0 = gathered_r[7:0];
  assign b1 = gathered_r[15:8];
  assign b2 = gathered_r[23:16];

  // Assemble as r,g,b in bits 23:16, 15:8, 7:0.
  always_comb begin
    unique case (pixel_format_r)
      FMT_PAL8:  asm_rgb = pal_ok_r ? pal_rd_r : 24'd0;
      FMT_RGB16: asm_rgb = {s1_byte_r[6:2], 3'b000,
                            s1_byte_r[1:0], b0[7:5], 3'b000,
                            b0[4:0], 3'b000};
      FMT_RGB24: asm_rgb = {s1_byte_r, b1, b0};
      FMT_RGB32: asm_rgb = {b2, b1, b0};
      default:   asm_rgb = 24'd0;
    endcase
  end

  always_comb begin
    run_count_nxt     = run_count_r;
    run_is_repeat_nxt = run_is_repeat_r;
    held_valid_nxt    = held_valid_r;
    held_rgb_nxt      = held_rgb_r;
    gathered_nxt      = gathered_r;
    byte_pos_nxt      = byte_pos_r;
    valid_c           = 1'b0;
    misuse_c          = 1'b0;
    pix_rgb           = held_rgb_r;

    unique case (s1_func_r)
      FUNC_START: begin
        // end any run, drop partial pixel
        run_count_nxt     = 8'd0;
        run_is_repeat_nxt = 1'b0;
        held_valid_nxt    = 1'b0;
        gathered_nxt      = 24'd0;
        byte_pos_nxt      = 2'd0;
      end
      FUNC_PAL: ;
      FUNC_STEP: begin
        if (holding) begin
          valid_c       = 1'b1;
          run_count_nxt = run_count_r - 8'd1;
        end else begin
          misuse_c = 1'b1;
        end
      end
      FUNC_BYTE: begin
        priority if (holding) begin
          misuse_c = 1'b1;
        end else if (compressed_r && run_count_r == 8'd0) begin
          // packet header: repeat run when top bit set, else literal run
          run_is_repeat_nxt = s1_byte_r[7];
          run_count_nxt     = s1_byte_r[7] ? (s1_byte_r - RepeatBase) : (s1_byte_r + 8'd1);
          held_valid_nxt    = 1'b0;
          gathered_nxt      = 24'd0;
          byte_pos_nxt      = 2'd0;
        end else if (byte_pos_r >= pixel_format_r) begin
          valid_c      = 1'b1;
          pix_rgb      = asm_rgb;
          gathered_nxt = 24'd0;
          byte_pos_nxt = 2'd0;
          if (compressed_r) begin
            if (run_is_repeat_r) begin
              held_rgb_nxt   = asm_rgb;
              held_valid_nxt = 1'b1;
            end
            run_count_nxt = run_count_r - 8'd1;
          end
        end else begin
          unique case (byte_pos_r)
            2'd0:    gathered_nxt = {gathered_r[23:8], gathered_r[7:0] | s1_byte_r};
            2'd1:    gathered_nxt = {gathered_r[23:16], gathered_r[15:8] | s1_byte_r,
                                     gathered_r[7:0]};
            2'd2:    gathered_nxt = {gathered_r[23:16] | s1_byte_r, gathered_r[15:0]};
            default: gathered_nxt = gathered_r;
          endcase
          byte_pos_nxt = byte_pos_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign holding_nxt = compressed_r && run_is_repeat_nxt && held_valid_nxt &&
                       (run_count_nxt != 8'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_count_r     <= 8'd0;
      run_is_repeat_r <= 1'b0;
      held_valid_r    <= 1'b0;
      held_rgb_r      <= 24'd0;
      gathered_r      <= 24'd0;
      byte_pos_r      <= 2'd0;
    end else if (s1_adv) begin
      run_count_r     <= run_count_nxt;
      run_is_repeat_r <= run_is_repeat_nxt;
      held_valid_r    <= held_valid_nxt;
      held_rgb_r      <= held_rgb_nxt;
      gathered_r      <= gathered_nxt;
      byte_pos_r      <= byte_pos_nxt;
    end
  end

  // ---------------- dither and 5-6-5 packing ----------------
  logic [3:0]  dth;
  logic [7:0]  r_d, g_d, b_d;
  logic [15:0] colour_c;

  assign dth = dither_enable_r ? dither_val(s1_x_r, s1_y_r) : 4'd0;
  assign r_d = sat_add(pix_rgb[23:16], dth);
  assign g_d = sat_add(pix_rgb[15:8], {1'b0, dth[3:1]});
  assign b_d = sat_add(pix_rgb[7:0], dth);

  // green's lowest kept bit is cleared
  assign colour_c = valid_c ? {r_d[7:3], g_d[7:3], 1'b0, b_d[7:3]} : 16'd0;

  // ---------------- result register ----------------
  logic [OutDataW-1:0] out_data_r;
  logic                out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {6'd0, misuse_c, !holding_nxt, colour_c};
      out_user_r <= valid_c;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/core/tga_rle_chk.sv
`default_nettype none

module tga_rle_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic [tga_rle_pkg::OutDataW-1:0] out_tdata,
  input wire logic                             out_tuser,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready
);
  import tga_rle_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  // no pixel means a zero colour
  a_zero_colour: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[15:0] == 16'd0)
    else $error("colour nonzero without pixel");

  // packed green keeps bit 5 cleared
  a_bit5: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[5])
    else $error("colour bit 5 set");

  // an ignored word never yields a pixel
  a_misuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> !out_tuser)
    else $error("misuse word carries a pixel");

  // drop results out of reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind tga_rle_pixel_decoder tga_rle_chk u_tga_rle_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
